>>> src/brc_pkg.sv
package brc_pkg;

  localparam logic OP_TEMP  = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  localparam int unsigned DivSteps = 32;

  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_stat_t;

  // Signed division by 2**k, truncating toward zero.
  function automatic logic [31:0] sdiv_pow2(input logic [31:0] a, input logic [4:0] k);
    logic [31:0] bias;
    bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    return 32'($signed(a + bias) >>> k);
  endfunction

endpackage

>>> src/brc_if.sv
interface brc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [23:0] raw_reading;
  logic [1:0]  oversampling;
  modport source(output valid, op, raw_reading, oversampling, input ready);
  modport sink(input valid, op, raw_reading, oversampling, output ready);
endinterface

interface brc_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [31:0] result_value;
  logic               divide_error;
  modport source(output valid, result_kind, result_value, divide_error, input ready);
  modport sink(input valid, result_kind, result_value, divide_error, output ready);
endinterface

>>> src/barometer_raw_compensation.sv
// Compensates raw barometer readings with the stored calibration words. Each
// item is worked through by a sequencer that steps one shared 32-bit
// multiplier and a radix-2 serial divider. The input is not ready while an
// item is being worked on. Every temperature item refreshes the stored B5
// used by later pressure items, unless its divisor was zero.
module barometer_raw_compensation
  import brc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  brc_in_if.sink      in_ch,
  brc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T0   = 5'd1;
  localparam logic [4:0] S_T1   = 5'd2;
  localparam logic [4:0] S_T2   = 5'd3;
  localparam logic [4:0] S_P0   = 5'd4;
  localparam logic [4:0] S_P1   = 5'd5;
  localparam logic [4:0] S_P2   = 5'd6;
  localparam logic [4:0] S_P3   = 5'd7;
  localparam logic [4:0] S_P4   = 5'd8;
  localparam logic [4:0] S_P5   = 5'd9;
  localparam logic [4:0] S_P6   = 5'd10;
  localparam logic [4:0] S_P7   = 5'd11;
  localparam logic [4:0] S_P8   = 5'd12;
  localparam logic [4:0] S_P9   = 5'd13;
  localparam logic [4:0] S_P10  = 5'd14;
  localparam logic [4:0] S_P11  = 5'd15;
  localparam logic [4:0] S_P12  = 5'd16;
  localparam logic [4:0] S_P13  = 5'd17;
  localparam logic [4:0] S_P14  = 5'd18;
  localparam logic [4:0] S_P15  = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  localparam logic [1:0] REG_A123 = 2'd0;
  localparam logic [1:0] REG_A456 = 2'd1;
  localparam logic [1:0] REG_B12  = 2'd2;
  localparam logic [1:0] REG_MCMD = 2'd3;

  logic [47:0] reg_a123;
  logic [47:0] reg_a456;
  logic [31:0] reg_b12;
  logic [31:0] reg_mcmd;
  logic [31:0] temp_intermediate;

  logic [4:0]  state;
  logic        op;
  logic [15:0] raw_t;
  logic [23:0] up;
  logic [1:0]  oss;
  logic [31:0] b6, sq, x1, x3, b3, b4, b7, p, q;
  logic        b7_small;
  logic [31:0] value;
  logic        err;

  logic        out_valid;
  logic        out_kind;
  logic [31:0] out_value;
  logic        out_err;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] den;

  div_ctl_t  div_ctl;
  div_stat_t div_stat;

  assign ac1 = {{16{reg_a123[47]}}, reg_a123[47:32]};
  assign ac2 = {{16{reg_a123[31]}}, reg_a123[31:16]};
  assign ac3 = {{16{reg_a123[15]}}, reg_a123[15:0]};
  assign ac4 = {16'd0, reg_a456[47:32]};
  assign ac5 = {16'd0, reg_a456[31:16]};
  assign ac6 = {16'd0, reg_a456[15:0]};
  assign b1  = {{16{reg_b12[31]}}, reg_b12[31:16]};
  assign b2  = {{16{reg_b12[15]}}, reg_b12[15:0]};
  assign mc  = {{16{reg_mcmd[31]}}, reg_mcmd[31:16]};
  assign md  = {{16{reg_mcmd[15]}}, reg_mcmd[15:0]};

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:3])
      REG_A123: prdata = {16'd0, reg_a123};
      REG_A456: prdata = {16'd0, reg_a456};
      REG_B12:  prdata = {32'd0, reg_b12};
      REG_MCMD: prdata = {32'd0, reg_mcmd};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a123 <= '0;
      reg_a456 <= '0;
      reg_b12  <= '0;
      reg_mcmd <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:3])
        REG_A123: reg_a123 <= pwdata[47:0];
        REG_A456: reg_a456 <= pwdata[47:0];
        REG_B12:  reg_b12  <= pwdata[31:0];
        REG_MCMD: reg_mcmd <= pwdata[31:0];
        default:  reg_mcmd <= reg_mcmd;
      endcase
    end
  end

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_T0:    begin mul_a = {16'd0, raw_t} - ac6; mul_b = ac5; end
      S_P0:    begin mul_a = temp_intermediate - 32'd4000;
                     mul_b = temp_intermediate - 32'd4000; end
      S_P1:    begin mul_a = b2; mul_b = sq; end
      S_P2:    begin mul_a = ac2; mul_b = b6; end
      S_P4:    begin mul_a = ac3; mul_b = b6; end
      S_P5:    begin mul_a = b1; mul_b = sq; end
      S_P7:    begin mul_a = ac4; mul_b = x3 + 32'h8000; end
      S_P8:    begin mul_a = {8'd0, up} - b3; mul_b = 32'd50000 >> oss; end
      S_P12:   begin mul_a = q; mul_b = q; end
      S_P13:   begin mul_a = x1; mul_b = 32'd3038; end
      S_P14:   begin mul_a = p; mul_b = -32'sd7357; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = 32'(mul_a * mul_b);
  assign den  = x1 + md;

  always_comb begin
    div_ctl = '0;
    if (state == S_T1 && den != 32'd0) begin
      div_ctl.start     = 1'b1;
      div_ctl.is_signed = 1'b1;
      div_ctl.dividend  = mc << 11;
      div_ctl.divisor   = den;
    end else if (state == S_P9) begin
      div_ctl.start     = 1'b1;
      div_ctl.is_signed = 1'b0;
      div_ctl.dividend  = b7_small ? (b7 << 1) : b7;
      div_ctl.divisor   = b4;
    end
  end

  brc_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .stat (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      temp_intermediate <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op    <= in_ch.op;
            raw_t <= in_ch.raw_reading[15:0];
            up    <= in_ch.raw_reading >> (4'd8 - {2'b00, in_ch.oversampling});
            oss   <= in_ch.oversampling;
            err   <= 1'b0;
            value <= '0;
            state <= (in_ch.op == OP_TEMP) ? S_T0 : S_P0;
          end
        end
        S_T0: begin
          x1    <= sdiv_pow2(prod, 5'd15);
          state <= S_T1;
        end
        S_T1: begin
          if (den == 32'd0) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_T2;
          end
        end
        S_T2: begin
          if (div_stat.done) begin
            temp_intermediate <= x1 + div_stat.quotient;
            value <= sdiv_pow2(x1 + div_stat.quotient + 32'd8, 5'd4);
            state <= S_DONE;
          end
        end
        S_P0: begin
          b6    <= temp_intermediate - 32'd4000;
          sq    <= sdiv_pow2(prod, 5'd12);
          state <= S_P1;
        end
        S_P1: begin
          x1    <= sdiv_pow2(prod, 5'd11);
          state <= S_P2;
        end
        S_P2: begin
          x3    <= x1 + sdiv_pow2(prod, 5'd11);
          state <= S_P3;
        end
        S_P3: begin
          b3    <= sdiv_pow2((((ac1 << 2) + x3) << oss) + 32'd2, 5'd2);
          state <= S_P4;
        end
        S_P4: begin
          x1    <= sdiv_pow2(prod, 5'd13);
          state <= S_P5;
        end
        S_P5: begin
          x3    <= x1 + sdiv_pow2(prod, 5'd16);
          state <= S_P6;
        end
        S_P6: begin
          x3    <= sdiv_pow2(x3 + 32'd2, 5'd2);
          state <= S_P7;
        end
        S_P7: begin
          b4    <= prod >> 15;
          state <= S_P8;
        end
        S_P8: begin
          if (b4 == 32'd0) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else begin
            b7       <= prod;
            b7_small <= !prod[31];
            state    <= S_P9;
          end
        end
        S_P9: begin
          state <= S_P10;
        end
        S_P10: begin
          if (div_stat.done) begin
            p     <= b7_small ? div_stat.quotient : (div_stat.quotient << 1);
            state <= S_P11;
          end
        end
        S_P11: begin
          q     <= sdiv_pow2(p, 5'd8);
          state <= S_P12;
        end
        S_P12: begin
          x1    <= prod;
          state <= S_P13;
        end
        S_P13: begin
          x1    <= sdiv_pow2(prod, 5'd16);
          state <= S_P14;
        end
        S_P14: begin
          x3    <= x1 + sdiv_pow2(prod, 5'd16);
          state <= S_P15;
        end
        S_P15: begin
          value <= p + sdiv_pow2(x3 + 32'd3791, 5'd4);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_kind  <= op;
            out_value <= value;
            out_err   <= err;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.result_kind  = out_kind;
  assign out_ch.result_value = out_value;
  assign out_ch.divide_error = out_err;

  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !div_stat.busy)
    else $error("input ready while the divider is busy");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input still ready after an item was accepted");

  a_error_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.divide_error) |-> (out_ch.result_value == 32'sd0))
    else $error("divide error with a nonzero value");

endmodule

>>> src/brc_divider.sv
module brc_divider
  import brc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_ctl_t  ctl,
  output div_stat_t stat
);

  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem, quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= 6'(DivSteps);
        quo  <= (ctl.is_signed && ctl.dividend[31]) ? -ctl.dividend : ctl.dividend;
        dsr  <= (ctl.is_signed && ctl.divisor[31]) ? -ctl.divisor : ctl.divisor;
        neg  <= ctl.is_signed && (ctl.dividend[31] ^ ctl.divisor[31]);
        rem  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= 32'(trial - {1'b0, dsr});
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy     = busy;
  assign stat.done     = done;
  assign stat.quotient = neg ? -quo : quo;

endmodule

>>> tb/brc_tb_pkg.sv
package brc_tb_pkg;

  // Byte addresses of the calibration registers (8-byte stride, widest is 48 bits).
  localparam logic [4:0] ADDR_AC1_AC2_AC3 = 5'd0;
  localparam logic [4:0] ADDR_AC4_AC5_AC6 = 5'd8;
  localparam logic [4:0] ADDR_B1_B2       = 5'd16;
  localparam logic [4:0] ADDR_MC_MD       = 5'd24;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
    logic               div_err;
  } reading_t;

endpackage

>>> tb/brc_checker.sv
module brc_checker
  import brc_pkg::*;
  import brc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  brc_in_if           in_ch,
  brc_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          temp_count,
  output int          press_count,
  output int          div_err_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0] cal_a123, cal_a456;
  logic [31:0] cal_b12, cal_mcmd;
  int          stored_b5;
  reading_t    expected_readings[$];

  function automatic int sdiv(int a, int b);
    if (b == -1) return -a;
    return a / b;
  endfunction

  // Computes one compensated reading; a good temperature item refreshes B5.
  function automatic reading_t compensate(logic op, logic [23:0] raw, logic [1:0] oss);
    reading_t    r;
    int          ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    int          ut, x1, x2, x3, den, b6, sq, b3;
    int unsigned up, t, b4, b7, pu;
    int          p, q;
    ac1 = int'($signed(cal_a123[47:32]));
    ac2 = int'($signed(cal_a123[31:16]));
    ac3 = int'($signed(cal_a123[15:0]));
    ac4 = int'({16'd0, cal_a456[47:32]});
    ac5 = int'({16'd0, cal_a456[31:16]});
    ac6 = int'({16'd0, cal_a456[15:0]});
    b1  = int'($signed(cal_b12[31:16]));
    b2  = int'($signed(cal_b12[15:0]));
    mc  = int'($signed(cal_mcmd[31:16]));
    md  = int'($signed(cal_mcmd[15:0]));
    r.kind = op;
    r.value = '0;
    r.div_err = 1'b0;
    if (op == OP_TEMP) begin
      ut = int'({16'd0, raw[15:0]});
      x1 = sdiv((ut - ac6) * ac5, 32768);
      den = x1 + md;
      if (den == 0) begin
        r.div_err = 1'b1;
      end else begin
        x2 = sdiv(mc * 2048, den);
        stored_b5 = x1 + x2;
        r.value = sdiv(stored_b5 + 8, 16);
      end
    end else begin
      up = {8'd0, raw} >> (8 - int'(oss));
      b6 = stored_b5 - 4000;
      sq = sdiv(b6 * b6, 4096);
      x1 = sdiv(b2 * sq, 2048);
      x2 = sdiv(ac2 * b6, 2048);
      x3 = x1 + x2;
      t = int'(unsigned'(ac1 * 4 + x3)) << oss;
      b3 = sdiv(int'(t) + 2, 4);
      x1 = sdiv(ac3 * b6, 8192);
      x2 = sdiv(b1 * sq, 65536);
      x3 = sdiv(x1 + x2 + 2, 4);
      b4 = (unsigned'(ac4) * (unsigned'(x3) + 32'd32768)) / 32'd32768;
      if (b4 == 0) begin
        r.div_err = 1'b1;
      end else begin
        b7 = (up - unsigned'(b3)) * (32'd50000 >> oss);
        if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
        else pu = (b7 / b4) * 2;
        p = int'(pu);
        q = sdiv(p, 256);
        x1 = q * q;
        x1 = sdiv(x1 * 3038, 65536);
        x2 = sdiv(-7357 * p, 65536);
        r.value = p + sdiv(x1 + x2 + 3791, 16);
      end
    end
    return r;
  endfunction

  assign pending = expected_readings.size();

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      cal_a123 <= '0;
      cal_a456 <= '0;
      cal_b12 <= '0;
      cal_mcmd <= '0;
      stored_b5 = 0;
      expected_readings.delete();
      fail_count <= 0;
      temp_count <= 0;
      press_count <= 0;
      div_err_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_AC1_AC2_AC3: cal_a123 <= pwdata[47:0];
          ADDR_AC4_AC5_AC6: cal_a456 <= pwdata[47:0];
          ADDR_B1_B2:       cal_b12 <= pwdata[31:0];
          ADDR_MC_MD:       cal_mcmd <= pwdata[31:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_readings.push_back(
            compensate(in_ch.op, in_ch.raw_reading, in_ch.oversampling));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result item: kind %0d value %0d", out_ch.result_kind,
                 out_ch.result_value);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_readings.pop_front();
          if (want.kind == OP_TEMP) temp_count <= temp_count + 1;
          else press_count <= press_count + 1;
          if (want.div_err) div_err_count <= div_err_count + 1;
          if (out_ch.result_kind !== want.kind ||
              out_ch.result_value !== want.value ||
              out_ch.divide_error !== want.div_err)
            fail_count <= fail_count + 1;
          if (out_ch.result_kind !== want.kind)
            $error("result_kind: expected %0d, got %0d", want.kind, out_ch.result_kind);
          if (out_ch.result_value !== want.value)
            $error("result_value: expected %0d, got %0d", want.value, out_ch.result_value);
          if (out_ch.divide_error !== want.div_err)
            $error("divide_error: expected %0d, got %0d", want.div_err,
                   out_ch.divide_error);
        end
      end
    end
  end

endmodule

>>> tb/barometer_raw_compensation_test.sv
module barometer_raw_compensation_test;
  import brc_pkg::*;
  import brc_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count, pending, temp_count, press_count, div_err_count;
  int          long_hold;
  bit          steady;

  brc_in_if  in_ch();
  brc_out_if out_ch();

  barometer_raw_compensation i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  brc_checker i_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending),
    .temp_count(temp_count), .press_count(press_count), .div_err_count(div_err_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    if (steady) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Result side: random short stalls, a few long ones, and a requested long hold.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        out_ch.ready <= (stall == 0);
      end
    end
  end

  task automatic reg_write(logic [4:0] addr, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits for every outstanding result, then lets the last item drain.
  task automatic drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic calibrate(logic [47:0] a123, logic [47:0] a456, logic [31:0] b12,
                           logic [31:0] mcmd);
    drain();
    reg_write(ADDR_AC1_AC2_AC3, {16'd0, a123});
    reg_write(ADDR_AC4_AC5_AC6, {16'd0, a456});
    reg_write(ADDR_B1_B2, {32'd0, b12});
    reg_write(ADDR_MC_MD, {32'd0, mcmd});
  endtask

  task automatic send(logic op, logic [23:0] raw, logic [1:0] oss);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.raw_reading <= raw;
    in_ch.oversampling <= oss;
    do @(posedge clk); while (!in_ch.ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [23:0] any_raw();
    return 24'($urandom);
  endfunction

  // Mostly a temperature item followed by a few pressure items, some noise.
  task automatic random_items(int count);
    int sent, n;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send(1'($urandom), any_raw(), 2'($urandom));
        sent++;
      end else begin
        send(OP_TEMP, ($urandom_range(0, 1) != 0) ?
             24'($urandom_range(20000, 36000)) : any_raw(), 2'($urandom));
        n = $urandom_range(1, 4);
        repeat (n)
          send(OP_PRESS, ($urandom_range(0, 1) != 0) ?
               24'($urandom_range(21'h100000, 21'h1FFFFF) << 3) : any_raw(), 2'($urandom));
        sent += n + 1;
      end
    end
  endtask

  function automatic logic [15:0] nudge(logic [15:0] v);
    return v + 16'($signed(10'($urandom)));
  endfunction

  initial begin
    logic [47:0] a123, a456;
    logic [31:0] b12, mcmd;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_TEMP;
    in_ch.raw_reading = '0;
    in_ch.oversampling = '0;
    long_hold = 0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset calibration: pressure before any temperature, both divisors zero.
    send(OP_PRESS, 24'hFFFFFF, 2'd3);
    send(OP_TEMP, 24'h000000, 2'd0);
    send(OP_PRESS, 24'h000000, 2'd0);

    // Typical calibration words.
    calibrate({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
              {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    steady = 1'b1;
    send(OP_PRESS, 24'h5D2300, 2'd0);
    send(OP_TEMP, 24'd27898, 2'd3);
    send(OP_TEMP, 24'hFF6CFA, 2'd1);
    for (int o = 0; o < 4; o++) send(OP_PRESS, 24'h5D23A7, 2'(o));
    send(OP_PRESS, 24'hFFFFFF, 2'd3);
    send(OP_PRESS, 24'h000000, 2'd0);
    send(OP_TEMP, 24'h00FFFF, 2'd0);
    send(OP_PRESS, 24'hFFFFFF, 2'd0);
    send(OP_TEMP, 24'h000000, 2'd2);
    send(OP_PRESS, 24'h800000, 2'd2);
    steady = 1'b0;

    // Extremes: every calibration bit set, then a zero temperature divisor.
    calibrate('1, '1, '1, '1);
    send(OP_TEMP, 24'h00FFFF, 2'd0);
    send(OP_PRESS, 24'hFFFFFF, 2'd3);
    send(OP_TEMP, 24'h123456, 2'd0);
    send(OP_PRESS, 24'h000001, 2'd1);
    calibrate('0, {16'd1, 16'd0, 16'd0}, '0, '0);
    send(OP_TEMP, 24'h00ABCD, 2'd0);
    send(OP_PRESS, 24'h654321, 2'd2);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 2 == 0) begin
        a123 = {nudge(16'd408), nudge(-16'sd72), nudge(-16'sd14383)};
        a456 = {nudge(16'd32741), nudge(16'd32757), nudge(16'd23153)};
        b12 = {nudge(16'd6190), nudge(16'd4)};
        mcmd = {nudge(-16'sd8711), nudge(16'd2868)};
      end else begin
        a123 = 48'({$urandom, $urandom});
        a456 = 48'({$urandom, $urandom});
        b12 = $urandom;
        mcmd = $urandom;
      end
      if (phase == 5) a456[47:32] = '0;
      if (phase == 7) begin
        a456[31:16] = '0;
        mcmd[15:0] = '0;
      end
      calibrate(a123, a456, b12, mcmd);
      steady = (phase == 3);
      if (phase == 2) long_hold <= 400;
      random_items(150);
    end
    steady = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d temperature and %0d pressure results, %0d with a zero divisor,",
             temp_count, press_count, div_err_count);
    $display("over reset, typical, all-ones and random calibration sets.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> barometer_raw_compensation.f
src/brc_pkg.sv
src/brc_if.sv
src/brc_divider.sv
src/barometer_raw_compensation.sv
tb/brc_tb_pkg.sv
tb/brc_checker.sv
tb/barometer_raw_compensation_test.sv
